[hdl/lph_pkg.sv]
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared constants, command and status codes, and the result beat layout.
// ----------------------------------------------------------------------------
package lph_pkg;

  // Default sizing handed to the top level parameters
  localparam int DefMaxSlots  = 256;
  localparam int DefValueBits = 32;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W8  = 8;
  localparam int LIVE_W   = 9;
  localparam int LG_W     = 4;

  // Size register reset and lower clamp
  localparam logic [LG_W-1:0] LG_RESET = 4'd8;
  localparam logic [LG_W-1:0] LG_MIN   = 4'd3;

  // Hash mixing multiplier
  localparam logic [KEY_W-1:0] HASH_MUL = 32'h045d9f3b;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND     = 3'd0,
    STAT_UPDATED   = 3'd1,
    STAT_INSERTED  = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_REMOVED   = 3'd4,
    STAT_FULL_CLR  = 3'd5
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [DATA_W-1:0]   data_out;
    logic [SLOT_W8-1:0]  slot;
    logic [LIVE_W-1:0]   live_entries;
  } lph_result_t;

endpackage

[hdl/linear_probe_hash_table_unit.sv]
// ----------------------------------------------------------------------------
// Linear probe hash table unit
// Open addressing integer hash table with tombstones and a full flag.
// ----------------------------------------------------------------------------
// Commands enter through a queue-style port and results leave in order, one
// per command. The front end takes a new command only once the last one has
// left it: two hash multiply rounds, four remainder steps of eight bits each,
// and a hand-off into a two-entry queue (clear skips the hashing). The back
// end probes one slot per cycle through the single registered read port of
// the slot memories, then hands the result on. Clear sweeps every slot; after
// reset the same sweep runs before the first command is carried out, though
// commands and size writes are taken meanwhile. The size register may only be
// written while no command is in flight.
module linear_probe_hash_table_unit
  import lph_pkg::*;
#(
  parameter int MAX_SLOTS  = DefMaxSlots,
  parameter int VALUE_BITS = DefValueBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command side
  input  logic                push,
  output logic                full,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [DATA_W-1:0]   data_in_i,
  // result side
  input  logic                pop,
  output logic                empty,
  output logic [STATUS_W-1:0] status_o,
  output logic [DATA_W-1:0]   data_out_o,
  output logic [SLOT_W8-1:0]  slot_o,
  output logic [LIVE_W-1:0]   live_entries_o,
  // size register
  input  logic                cfg_we_i,
  input  logic [LG_W-1:0]     cfg_data_i
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int SZ_W   = SLOT_W + 1;
  localparam int ENT_W  = CMD_W + KEY_W + DATA_W + SLOT_W;
  localparam int RES_W  = $bits(lph_result_t);
  localparam logic [LG_W-1:0] SlotW4 = LG_W'(SLOT_W);

  logic [LG_W-1:0]  lg_q;
  logic [LG_W-1:0]  lg_eff;
  logic [SZ_W-1:0]  size;

  logic             cq_push, cq_full, cq_pop, cq_empty;
  logic [ENT_W-1:0] cq_wdata, cq_rdata;
  logic             rq_push;
  logic             rq_full_w;
  logic [RES_W-1:0] rq_wdata, rq_rdata;
  lph_result_t      res;

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= LG_RESET;
    end else if (cfg_we_i) begin
      lg_q <= cfg_data_i;
    end
  end

  // active slot count: clamped power of two, capped at the slot memory depth
  assign lg_eff = (lg_q < LG_MIN) ? LG_MIN : lg_q;
  assign size   = (lg_eff >= SlotW4) ? SZ_W'(MAX_SLOTS) : (SZ_W'(1) << lg_eff);

  lph_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .command_i (command_i),
    .key_i     (key_i),
    .data_in_i (data_in_i),
    .size_i    (size),
    .q_push_o  (cq_push),
    .q_data_o  (cq_wdata),
    .q_full_i  (cq_full)
  );

  lph_fifo #(
    .WIDTH (ENT_W)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cq_wdata),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .data_o  (cq_rdata),
    .empty_o (cq_empty)
  );

  lph_back #(
    .MAX_SLOTS  (MAX_SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size),
    .q_empty_i  (cq_empty),
    .q_data_i   (cq_rdata),
    .q_pop_o    (cq_pop),
    .res_full_i (rq_full_w),
    .res_push_o (rq_push),
    .res_o      (rq_wdata)
  );

  lph_fifo #(
    .WIDTH (RES_W)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_wdata),
    .full_o  (rq_full_w),
    .pop_i   (pop),
    .data_o  (rq_rdata),
    .empty_o (empty)
  );

  // result beat fields
  assign res            = lph_result_t'(rq_rdata);
  assign status_o       = res.status;
  assign data_out_o     = res.data_out;
  assign slot_o         = res.slot;
  assign live_entries_o = res.live_entries;

endmodule

[hdl/lph_fifo.sv]
// ----------------------------------------------------------------------------
// Two-entry queue
// Small decoupling queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module lph_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[hdl/lph_front.sv]
// ----------------------------------------------------------------------------
// Hash table front end
// Accepts command beats, hashes the key and reduces it to a home slot.
// ----------------------------------------------------------------------------
module lph_front
  import lph_pkg::*;
#(
  parameter int MAX_SLOTS = DefMaxSlots,
  parameter int SLOT_W    = $clog2(MAX_SLOTS),
  parameter int SZ_W      = SLOT_W + 1,
  parameter int ENT_W     = CMD_W + KEY_W + DATA_W + SLOT_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [DATA_W-1:0] data_in_i,
  input  logic [SZ_W-1:0]   size_i,
  output logic              q_push_o,
  output logic [ENT_W-1:0]  q_data_o,
  input  logic              q_full_i
);

  typedef enum logic [4:0] {
    F_IDLE   = 5'b00001,
    F_MUL1   = 5'b00010,
    F_MUL2   = 5'b00100,
    F_REDUCE = 5'b01000,
    F_PUSH   = 5'b10000
  } front_state_e;

  front_state_e      state_q, state_d;
  logic [1:0]        step_q, step_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [KEY_W-1:0]  x_q, x_d;
  logic [SLOT_W-1:0] rem_q, rem_d;

  logic [2*KEY_W-1:0] prod;
  logic [KEY_W-1:0]   mixed;
  logic [SLOT_W:0]    rw;
  logic [SLOT_W-1:0]  rem_step;

  assign full     = (state_q != F_IDLE);
  assign q_data_o = {cmd_q, key_q, data_q, rem_q};
  assign q_push_o = (state_q == F_PUSH);

  // one multiply round followed by the xor-shift fold
  assign prod  = (2*KEY_W)'(x_q) * (2*KEY_W)'(HASH_MUL);
  assign mixed = prod[KEY_W-1:0] ^ {16'd0, prod[KEY_W-1:16]};

  // remainder by the active size, eight hash bits per step
  always_comb begin
    rem_step = rem_q;
    rw       = '0;
    for (int i = 0; i < 8; i++) begin
      rw = {rem_step, x_q[KEY_W-1-i]};
      if (rw >= size_i) begin
        rw = rw - size_i;
      end
      rem_step = rw[SLOT_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_d   = cmd_q;
    key_d   = key_q;
    data_d  = data_q;
    x_d     = x_q;
    rem_d   = rem_q;
    case (state_q)
      F_IDLE: begin
        if (push) begin
          cmd_d  = command_i;
          key_d  = key_i;
          data_d = data_in_i;
          x_d    = key_i ^ {16'd0, key_i[KEY_W-1:16]};
          rem_d  = '0;
          step_d = 2'd0;
          state_d = (cmd_e'(command_i) == CMD_CLEAR) ? F_PUSH : F_MUL1;
        end
      end
      F_MUL1: begin
        x_d     = mixed;
        state_d = F_MUL2;
      end
      F_MUL2: begin
        x_d     = mixed;
        state_d = F_REDUCE;
      end
      F_REDUCE: begin
        rem_d  = rem_step;
        x_d    = {x_q[KEY_W-9:0], 8'd0};
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    data_q <= data_d;
    x_q    <= x_d;
    rem_q  <= rem_d;
  end

endmodule

[hdl/lph_back.sv]
// ----------------------------------------------------------------------------
// Hash table back end
// Walks the probe sequence over the slot memories, applies the command and
// forms the result beat. Also runs the slot clearing sweep.
// ----------------------------------------------------------------------------
module lph_back
  import lph_pkg::*;
#(
  parameter int MAX_SLOTS  = DefMaxSlots,
  parameter int VALUE_BITS = DefValueBits,
  parameter int SLOT_W     = $clog2(MAX_SLOTS),
  parameter int SZ_W       = SLOT_W + 1,
  parameter int CNT_W      = $clog2(MAX_SLOTS + 1),
  parameter int ENT_W      = CMD_W + KEY_W + DATA_W + SLOT_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [SZ_W-1:0]            size_i,
  input  logic                       q_empty_i,
  input  logic [ENT_W-1:0]           q_data_i,
  output logic                       q_pop_o,
  input  logic                       res_full_i,
  output logic                       res_push_o,
  output logic [$bits(lph_result_t)-1:0] res_o
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_PROBE = 4'b0010,
    B_DONE  = 4'b0100,
    B_SWEEP = 4'b1000
  } back_state_e;

  typedef enum logic [1:0] {
    SL_EMPTY = 2'b00,
    SL_LIVE  = 2'b01,
    SL_TOMB  = 2'b10
  } slot_st_e;

  // slot memories
  slot_st_e              st_mem_q  [MAX_SLOTS];
  logic [KEY_W-1:0]      key_mem_q [MAX_SLOTS];
  logic [VALUE_BITS-1:0] val_mem_q [MAX_SLOTS];
  slot_st_e              st_rd_q;
  logic [KEY_W-1:0]      key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;

  back_state_e           state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [VALUE_BITS-1:0] data_q, data_d;
  logic [SLOT_W-1:0]     probe_q, probe_d;
  logic [SZ_W-1:0]       n_q, n_d;
  logic                  tomb_seen_q, tomb_seen_d;
  logic [SLOT_W-1:0]     tomb_q, tomb_d;
  logic [SLOT_W-1:0]     sweep_q, sweep_d;
  logic                  init_q, init_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  lph_result_t           res_q, res_d;

  // write port controls
  logic                  st_we, key_we, val_we;
  slot_st_e              st_wdata;
  logic [SLOT_W-1:0]     w_addr;

  // probe decode
  logic                  cur_empty, cur_tomb, cur_hit, last;
  logic                  tomb_any;
  logic [SLOT_W-1:0]     tomb_slot, next_slot;
  logic [SZ_W-1:0]       n_inc, probe_inc;
  logic [SLOT_W-1:0]     fin_slot;
  logic [SLOT_W+SLOT_W8-1:0] fin_ext;
  logic [VALUE_BITS+DATA_W-1:0] wr_ext;
  logic [VALUE_BITS+DATA_W-1:0] rd_ext;
  logic [CNT_W+LIVE_W-1:0]      cnt_ext;
  lph_result_t           res_out;

  // queue entry fields
  cmd_e                  ent_cmd;
  logic [KEY_W-1:0]      ent_key;
  logic [DATA_W-1:0]     ent_data;
  logic [SLOT_W-1:0]     ent_home;

  assign ent_cmd  = cmd_e'(q_data_i[ENT_W-1 -: CMD_W]);
  assign ent_key  = q_data_i[ENT_W-CMD_W-1 -: KEY_W];
  assign ent_data = q_data_i[SLOT_W +: DATA_W];
  assign ent_home = q_data_i[SLOT_W-1:0];

  // stored value keeps the low value bits of the input word
  assign wr_ext = {{VALUE_BITS{1'b0}}, ent_data};
  assign rd_ext = {{DATA_W{1'b0}}, val_rd_q};

  // slot under test
  assign cur_empty = (st_rd_q == SL_EMPTY);
  assign cur_tomb  = (st_rd_q == SL_TOMB);
  assign cur_hit   = (st_rd_q == SL_LIVE) && (key_rd_q == key_q);
  assign n_inc     = n_q + SZ_W'(1);
  assign last      = (n_inc == size_i);
  assign probe_inc = {1'b0, probe_q} + SZ_W'(1);
  assign next_slot = (probe_inc == size_i) ? '0 : probe_inc[SLOT_W-1:0];
  assign tomb_any  = tomb_seen_q | cur_tomb;
  assign tomb_slot = tomb_seen_q ? tomb_q : probe_q;

  // result beat: live count taken after the command has settled
  assign cnt_ext    = {{LIVE_W{1'b0}}, cnt_q};
  always_comb begin
    res_out              = res_q;
    res_out.live_entries = cnt_ext[LIVE_W-1:0];
  end
  assign res_o      = res_out;
  assign res_push_o = (state_q == B_DONE);

  // control
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    data_d      = data_q;
    probe_d     = probe_q;
    n_d         = n_q;
    tomb_seen_d = tomb_seen_q;
    tomb_d      = tomb_q;
    sweep_d     = sweep_q;
    init_d      = init_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    st_we       = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    st_wdata    = SL_EMPTY;
    w_addr      = probe_q;
    fin_slot    = '0;
    fin_ext     = '0;

    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o     = 1'b1;
          cmd_d       = ent_cmd;
          key_d       = ent_key;
          data_d      = wr_ext[VALUE_BITS-1:0];
          probe_d     = ent_home;
          n_d         = '0;
          tomb_seen_d = 1'b0;
          sweep_d     = '0;
          state_d     = (ent_cmd == CMD_CLEAR) ? B_SWEEP : B_PROBE;
        end
      end

      B_PROBE: begin
        if (cur_hit || cur_empty || last) begin
          res_d.data_out = '0;
          res_d.status   = STAT_NOT_FOUND;
          if (cur_hit) begin
            fin_slot = probe_q;
            case (cmd_q)
              CMD_LOOKUP: begin
                res_d.status   = STAT_FOUND;
                res_d.data_out = rd_ext[DATA_W-1:0];
              end
              CMD_INSERT: begin
                res_d.status = STAT_UPDATED;
                val_we       = 1'b1;
              end
              default: begin
                res_d.status   = STAT_REMOVED;
                res_d.data_out = rd_ext[DATA_W-1:0];
                st_we          = 1'b1;
                st_wdata       = SL_TOMB;
                if (cnt_q != '0) begin
                  cnt_d = cnt_q - CNT_W'(1);
                end
              end
            endcase
          end else if (cmd_q == CMD_INSERT) begin
            if (tomb_any || cur_empty) begin
              // reuse the first tombstone, else the empty slot that ended the walk
              fin_slot     = tomb_any ? tomb_slot : probe_q;
              w_addr       = fin_slot;
              st_we        = 1'b1;
              key_we       = 1'b1;
              val_we       = 1'b1;
              st_wdata     = SL_LIVE;
              cnt_d        = cnt_q + CNT_W'(1);
              res_d.status = STAT_INSERTED;
            end else begin
              res_d.status = STAT_FULL_CLR;
            end
          end
          fin_ext    = {{SLOT_W8{1'b0}}, fin_slot};
          res_d.slot = fin_ext[SLOT_W8-1:0];
          state_d    = B_DONE;
        end else begin
          if (cur_tomb && !tomb_seen_q) begin
            tomb_seen_d = 1'b1;
            tomb_d      = probe_q;
          end
          n_d     = n_inc;
          probe_d = next_slot;
        end
      end

      B_DONE: begin
        if (!res_full_i) begin
          state_d = B_IDLE;
        end
      end

      B_SWEEP: begin
        st_we    = 1'b1;
        st_wdata = SL_EMPTY;
        w_addr   = sweep_q;
        if (sweep_q == SLOT_W'(MAX_SLOTS - 1)) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = B_IDLE;
          end else begin
            cnt_d          = '0;
            res_d.status   = STAT_FULL_CLR;
            res_d.data_out = '0;
            res_d.slot     = '0;
            state_d        = B_DONE;
          end
        end else begin
          sweep_d = sweep_q + SLOT_W'(1);
        end
      end

      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_SWEEP;
      sweep_q     <= '0;
      init_q      <= 1'b1;
      cnt_q       <= '0;
      tomb_seen_q <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      tomb_seen_q <= tomb_seen_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    data_q  <= data_d;
    probe_q <= probe_d;
    tomb_q  <= tomb_d;
    res_q   <= res_d;
  end

  // slot memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem_q[w_addr] <= st_wdata;
    end
    st_rd_q <= st_mem_q[probe_d];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem_q[w_addr] <= key_q;
    end
    key_rd_q <= key_mem_q[probe_d];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem_q[w_addr] <= data_q;
    end
    val_rd_q <= val_mem_q[probe_d];
  end

endmodule

[verif/linear_probe_hash_table_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear probe hash table unit testbench
// Drives lookup, insert, remove and clear commands through the command queue
// and checks each result beat against a tracking copy of the table. A short
// directed pass hits the key extremes, missing keys, updates, tombstone reuse,
// table full and clear. Random phases follow across several table sizes, with
// idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit_test;
  import lph_pkg::*;

  localparam int TableSlots   = DefMaxSlots;
  localparam int MaxSizeLog2  = 12;
  localparam int SettleCycles = 300;    // clear sweep plus hashing, with margin
  localparam int StallLimit   = 5000;   // cycles without any beat
  localparam int HoldCycles   = 400;    // long receiver hold-off
  localparam int RandomPhases = 8;
  localparam int PhaseItems   = 241;

  localparam logic [KEY_W-1:0] KeyMin = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KeyMax = 32'h7fff_ffff;

  // Tracks table contents and holds the results still owed by the block
  class hash_table_scoreboard;
    logic [KEY_W-1:0]  key_mem   [TableSlots];
    logic [DATA_W-1:0] value_mem [TableSlots];
    bit                occ       [TableSlots];
    bit                tomb      [TableSlots];
    int unsigned       live;
    logic [LG_W-1:0]   size_lg;
    lph_result_t       due_results [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       status_seen [6];

    function new();
      live    = 0;
      size_lg = LG_RESET;
      errors  = 0;
      checked = 0;
      foreach (occ[i]) begin
        occ[i]  = 1'b0;
        tomb[i] = 1'b0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_size(logic [LG_W-1:0] lg);
      size_lg = lg;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Clamp to 3..12, then cap at the physical slot count
    function int active_slots();
      int lg;
      lg = size_lg;
      if (lg < LG_MIN) lg = LG_MIN;
      if (lg > MaxSizeLog2) lg = MaxSizeLog2;
      return ((1 << lg) > TableSlots) ? TableSlots : (1 << lg);
    endfunction

    // Two xor-shift-multiply rounds and a closing xor-shift
    function logic [KEY_W-1:0] mix_key(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] x;
      x = k;
      x = ((x >> 16) ^ x) * HASH_MUL;
      x = ((x >> 16) ^ x) * HASH_MUL;
      return (x >> 16) ^ x;
    endfunction

    // Apply one command to the tracked table and return its result beat
    function lph_result_t table_outcome(cmd_e cmd, logic [KEY_W-1:0] key,
                                        logic [DATA_W-1:0] data);
      lph_result_t r;
      int slots, s, hit, empty_at, tomb_at, dst;
      r.status   = STAT_NOT_FOUND;
      r.data_out = '0;
      r.slot     = '0;
      hit      = -1;
      empty_at = -1;
      tomb_at  = -1;
      if (cmd == CMD_CLEAR) begin
        foreach (occ[i]) begin
          occ[i]  = 1'b0;
          tomb[i] = 1'b0;
        end
        live     = 0;
        r.status = STAT_FULL_CLR;
      end else begin
        slots = active_slots();
        s = int'(mix_key(key) & (slots - 1));
        // walk upward with wrap; tombstones are skipped but remembered
        for (int n = 0; n < slots && hit < 0 && empty_at < 0; n++) begin
          if (!occ[s]) empty_at = s;
          else if (tomb[s]) begin
            if (tomb_at < 0) tomb_at = s;
          end else if (key_mem[s] == key) hit = s;
          s = (s + 1) % slots;
        end
        if (hit >= 0) begin
          r.slot = SLOT_W8'(hit);
          case (cmd)
            CMD_LOOKUP: begin
              r.status   = STAT_FOUND;
              r.data_out = value_mem[hit];
            end
            CMD_INSERT: begin
              r.status       = STAT_UPDATED;
              value_mem[hit] = data;
            end
            default: begin
              r.status   = STAT_REMOVED;
              r.data_out = value_mem[hit];
              tomb[hit]  = 1'b1;
              if (live > 0) live--;
            end
          endcase
        end else if (cmd == CMD_INSERT) begin
          dst = (tomb_at >= 0) ? tomb_at : empty_at;
          if (dst < 0) r.status = STAT_FULL_CLR;
          else begin
            r.slot         = SLOT_W8'(dst);
            key_mem[dst]   = key;
            value_mem[dst] = data;
            occ[dst]       = 1'b1;
            tomb[dst]      = 1'b0;
            live++;
            r.status       = STAT_INSERTED;
          end
        end
      end
      r.live_entries = LIVE_W'(live);
      return r;
    endfunction

    function void note_command(cmd_e cmd, logic [KEY_W-1:0] key, logic [DATA_W-1:0] data);
      due_results.push_back(table_outcome(cmd, key, data));
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                logic [DATA_W-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] dout,
                               logic [SLOT_W8-1:0] sl, logic [LIVE_W-1:0] lv);
      lph_result_t exp_r;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing, got status %0d",
                 $time, st);
        return;
      end
      exp_r = due_results.pop_front();
      checked++;
      status_seen[exp_r.status]++;
      compare_field("status", exp_r.status, st);
      compare_field("data_out", exp_r.data_out, dout);
      compare_field("slot", exp_r.slot, sl);
      compare_field("live_entries", exp_r.live_entries, lv);
    endfunction
  endclass

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                push       = 1'b0;
  logic                full;
  logic [CMD_W-1:0]    command_i  = '0;
  logic [KEY_W-1:0]    key_i      = '0;
  logic [DATA_W-1:0]   data_in_i  = '0;
  logic                pop        = 1'b0;
  logic                empty;
  logic [STATUS_W-1:0] status_o;
  logic [DATA_W-1:0]   data_out_o;
  logic [SLOT_W8-1:0]  slot_o;
  logic [LIVE_W-1:0]   live_entries_o;
  logic                cfg_we_i   = 1'b0;
  logic [LG_W-1:0]     cfg_data_i = '0;

  hash_table_scoreboard sb = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit rx_hold_req  = 1'b0;
  int quiet_cycles = 0;
  int size_writes  = 0;

  logic [LG_W-1:0] size_plan [RandomPhases] =
    '{4'd3, 4'd15, 4'd4, 4'd0, 4'd5, 4'd12, 4'd6, 4'd2};

  linear_probe_hash_table_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .key_i          (key_i),
    .data_in_i      (data_in_i),
    .pop            (pop),
    .empty          (empty),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .slot_o         (slot_o),
    .live_entries_o (live_entries_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no beat for %0d cycles", $time, StallLimit);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        repeat (HoldCycles) begin
          @(negedge clk_i);
          pop <= 1'b0;
          @(posedge clk_i);
        end
      end
      @(negedge clk_i);
      pop <= ($urandom_range(99) >= rx_stall_pct);
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(status_o, data_out_o, slot_o, live_entries_o);
    end
  end

  // Offer one command beat, with random idle cycles ahead of it
  task automatic send_command(cmd_e cmd, logic [KEY_W-1:0] key, logic [DATA_W-1:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push      <= 1'b1;
    command_i <= cmd;
    key_i     <= key;
    data_in_i <= data;
    do @(posedge clk_i); while (full);
    sb.note_command(cmd, key, data);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Size writes only with nothing in flight
  task automatic write_size(logic [LG_W-1:0] lg);
    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= lg;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_size(lg);
    size_writes++;
  endtask

  // Mostly commands on a small key pool so hits, tombstones and full tables occur
  task automatic run_random_phase(int items, int mode);
    logic [KEY_W-1:0]  pool [$];
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    cmd_e              cmd;
    int                pool_len, slots, r, d;
    slots    = sb.active_slots();
    pool_len = slots + slots / 2 + 2;
    if (pool_len > 48) pool_len = 48;
    for (int i = 0; i < pool_len; i++) pool.push_back($urandom());
    case (mode)
      0: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b1;
      end
      1: begin
        tx_idle_pct  = 64;
        rx_stall_pct = 0;
      end
      2: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 64;
      end
      default: begin
        tx_idle_pct  = 21;
        rx_stall_pct = 21;
      end
    endcase
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) pause_until_drained();
      r = $urandom_range(999);
      d = $urandom_range(15);
      data = (d == 0) ? '0 : (d == 1) ? '1 : $urandom();
      key  = pool[$urandom_range(pool_len - 1)];
      if (r < 10) cmd = CMD_CLEAR;
      else if (r < 60) begin
        // noise: any key, any non-clear command
        cmd = cmd_e'($urandom_range(2));
        key = $urandom();
      end else if (r < 510) cmd = CMD_INSERT;
      else if (r < 810) cmd = CMD_LOOKUP;
      else cmd = CMD_REMOVE;
      send_command(cmd, key, data);
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass on the full-size table
    write_size(LG_RESET);
    send_command(CMD_LOOKUP, KeyMin, 32'h1111_1111);   // absent key
    send_command(CMD_REMOVE, KeyMin, '0);              // remove absent key
    send_command(CMD_INSERT, KeyMin, 32'hffff_ffff);
    send_command(CMD_INSERT, KeyMax, 32'h0000_0000);
    send_command(CMD_INSERT, 32'h0, 32'h5a5a_5a5a);
    send_command(CMD_INSERT, 32'hffff_ffff, 32'ha5a5_a5a5);
    send_command(CMD_LOOKUP, KeyMin, '0);
    send_command(CMD_INSERT, KeyMin, 32'h1234_5678);   // update in place
    send_command(CMD_LOOKUP, KeyMin, '0);
    send_command(CMD_REMOVE, KeyMax, '0);
    send_command(CMD_LOOKUP, KeyMax, '0);              // now a tombstone
    send_command(CMD_INSERT, KeyMax, 32'hdead_beef);   // reuses the tombstone
    send_command(CMD_REMOVE, 32'h0, '0);
    send_command(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    send_command(CMD_LOOKUP, 32'hffff_ffff, '0);

    // Size below range clamps to eight slots; the ninth insert finds it full
    write_size(4'd0);
    for (int i = 0; i < 9; i++) send_command(CMD_INSERT, 32'h0000_1000 + i, $urandom());

    for (int p = 0; p < RandomPhases; p++) begin
      write_size(size_plan[p]);
      run_random_phase(PhaseItems, p % 4);
    end

    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Summary: %0d result beats checked, %0d size writes, sizes 8 to 256 slots",
             sb.checked, size_writes);
    $display("Statuses: found %0d, updated %0d, inserted %0d, absent %0d, removed %0d, %s %0d",
             sb.status_seen[STAT_FOUND], sb.status_seen[STAT_UPDATED],
             sb.status_seen[STAT_INSERTED], sb.status_seen[STAT_NOT_FOUND],
             sb.status_seen[STAT_REMOVED], "full or cleared", sb.status_seen[STAT_FULL_CLR]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
